FILE: design/idal_pkg.sv
// Shared constants and types for the next-fit identifier allocator.
// No dependencies; used by idal_ffs and id_allocator_next_fit_core.
package idal_pkg;

  // bitmap row width and its log
  localparam int WORD_W    = 64;
  localparam int LOG2_WORD = 6;

  // identifier field width on the stream ports
  localparam int ID_W = 13;

  localparam int DEF_FIRST_ID = 300;
  localparam int DEF_NUM_IDS  = 4096;

  // command codes (value 3 is ignored)
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DONE
  } state_t;

endpackage

FILE: design/idal_bitmap.sv
// Used/free bitmap storage: one write port, one read port, registered read.
// No dependencies.
module idal_bitmap #(
  parameter int DEPTH  = 64,
  parameter int AW     = 6,
  parameter int W      = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/idal_ffs.sv
// Find-first-set over one bitmap row: lowest set bit of a candidate mask.
// Depends on idal_pkg.
module idal_ffs (
  input  logic [idal_pkg::WORD_W-1:0]    cand,
  output logic                           found,
  output logic [idal_pkg::LOG2_WORD-1:0] idx
);
  import idal_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = LOG2_WORD'(i);
      end
    end
  end

  assign found = |cand;

endmodule

FILE: design/id_allocator_next_fit_core.sv
// Next-fit identifier allocator over FIRST_ID .. FIRST_ID+NUM_IDS-1.
// Depends on idal_pkg, idal_bitmap, idal_ffs.
//
// The used/free bitmap sits in one synchronous memory of 64-bit rows, read
// one row per cycle. After reset a clearing pass zeroes the memory, one row
// a cycle, all ceil(NUM_IDS/64) rows (64 at the default size); no command is
// taken meanwhile. One command is worked at a time. In-range release and
// query go from accept through the row read to the result register;
// out-of-range ones and the unused command skip the row read.
// An allocate scans rows starting at the row holding the slot after the last
// one handed out, wrapping at the top, and revisits the start row last for
// the bits below the start point, one row at a time through the single
// bitmap read port. An exhausted allocate takes the full scan.
// The input is taken again while a finished result still waits on m_tready.
// Identifiers outside the range report status 2 and leave the state alone.
module id_allocator_next_fit_core #(
  parameter int FIRST_ID = idal_pkg::DEF_FIRST_ID,
  parameter int NUM_IDS  = idal_pkg::DEF_NUM_IDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] id_in, [15:13] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [12:0] id_out, [14:13] status, [15] in_use
);
  import idal_pkg::*;

  localparam int SLOT_W    = $clog2(NUM_IDS);
  localparam int NWORDS    = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W     = $clog2(NWORDS + 1);
  localparam int LAST_BITS = NUM_IDS - (NWORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

  state_t state, state_next;

  logic [1:0]           cmd_r, cmd_next;
  logic [WADDR_W-1:0]   cur_word, cur_word_next;
  logic [LOG2_WORD-1:0] bit_r, bit_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [WADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [SLOT_W-1:0]    last_given, last_given_next;
  logic [ID_W-1:0]      res_id, res_id_next;
  logic [1:0]           res_status, res_status_next;
  logic                 res_in_use, res_in_use_next;
  logic                 out_load;

  // bitmap port
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0]    mem_wdata, rd_data;

  // search
  logic [WORD_W-1:0]    cand, win_mask, lim_mask;
  logic                 found;
  logic [LOG2_WORD-1:0] idx;

  // input decode
  logic [31:0]          id32, pos32;
  logic                 in_range;
  logic [SLOT_W-1:0]    start_slot, sel_slot;

  idal_bitmap #(
    .DEPTH (NWORDS),
    .AW    (WADDR_W),
    .W     (WORD_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  idal_ffs u_ffs (
    .cand  (cand),
    .found (found),
    .idx   (idx)
  );

  assign s_tready = (state == S_IDLE);

  assign id32     = {19'd0, s_tdata[ID_W-1:0]};
  assign in_range = (id32 >= 32'(FIRST_ID)) && ((id32 - 32'(FIRST_ID)) < 32'(NUM_IDS));

  assign start_slot = (last_given == SLOT_W'(NUM_IDS - 1)) ? '0 : last_given + 1'b1;
  assign sel_slot   = (s_tuser == CMD_ALLOC) ? start_slot
                                             : SLOT_W'(id32 - 32'(FIRST_ID));

  // first visit: bits at or above the start; wrap revisit: bits below it
  always_comb begin
    if (cnt == '0) begin
      win_mask = {WORD_W{1'b1}} << bit_r;
    end else if (cnt == CNT_W'(NWORDS)) begin
      win_mask = ~({WORD_W{1'b1}} << bit_r);
    end else begin
      win_mask = {WORD_W{1'b1}};
    end
  end

  // padding bits past the top of the range count as used
  assign lim_mask = (cur_word == WADDR_W'(NWORDS - 1)) ? LAST_MASK : {WORD_W{1'b1}};
  assign cand     = ~rd_data & lim_mask & win_mask;
  assign pos32    = (32'(cur_word) << LOG2_WORD) | 32'(idx);

  always_comb begin
    state_next      = state;
    cmd_next        = cmd_r;
    cur_word_next   = cur_word;
    bit_next        = bit_r;
    cnt_next        = cnt;
    clr_addr_next   = clr_addr;
    last_given_next = last_given;
    res_id_next     = res_id;
    res_status_next = res_status;
    res_in_use_next = res_in_use;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = cur_word;
    mem_wdata       = rd_data;
    mem_raddr       = cur_word;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == WADDR_W'(NWORDS - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_next        = s_tuser;
          res_id_next     = s_tdata[ID_W-1:0];
          res_status_next = ST_OK;
          res_in_use_next = 1'b0;
          cnt_next        = '0;
          cur_word_next   = WADDR_W'(32'(sel_slot) >> LOG2_WORD);
          bit_next        = LOG2_WORD'(32'(sel_slot));
          mem_raddr       = WADDR_W'(32'(sel_slot) >> LOG2_WORD);
          if (s_tuser == CMD_ALLOC) begin
            state_next = S_LOOK;
          end else if (s_tuser == CMD_RELEASE || s_tuser == CMD_QUERY) begin
            if (in_range) begin
              state_next = S_LOOK;
            end else begin
              res_status_next = ST_RANGE;
              state_next      = S_DONE;
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_LOOK: begin
        case (cmd_r)
          CMD_ALLOC: begin
            if (found) begin
              mem_we          = 1'b1;
              mem_wdata       = rd_data | (WORD_W'(1) << idx);
              last_given_next = SLOT_W'(pos32);
              res_id_next     = ID_W'(32'(FIRST_ID) + pos32);
              state_next      = S_DONE;
            end else if (cnt == CNT_W'(NWORDS)) begin
              res_id_next     = '0;
              res_status_next = ST_EXHAUSTED;
              state_next      = S_DONE;
            end else begin
              cnt_next      = cnt + 1'b1;
              cur_word_next = (cur_word == WADDR_W'(NWORDS - 1)) ? '0 : cur_word + 1'b1;
              mem_raddr     = cur_word_next;
            end
          end
          CMD_RELEASE: begin
            mem_we     = 1'b1;
            mem_wdata  = rd_data & ~(WORD_W'(1) << bit_r);
            state_next = S_DONE;
          end
          CMD_QUERY: begin
            res_in_use_next = rd_data[bit_r];
            state_next      = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      last_given <= SLOT_W'(NUM_IDS - 1);
      cnt        <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      last_given <= last_given_next;
      cnt        <= cnt_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_next;
    cur_word   <= cur_word_next;
    bit_r      <= bit_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    res_in_use <= res_in_use_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res_in_use, res_status, res_id};
    end
  end

  // scan never runs past the wrap revisit
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |-> cnt <= CNT_W'(NWORDS))
    else $error("scan count past wrap");

  // bitmap writes only from the clearing pass or a row update
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_LOOK || state == S_CLEAR))
    else $error("bitmap write outside update");

  // an accepted beat goes straight to the row read or the result
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> (state == S_LOOK || state == S_DONE))
    else $error("bad state after accept");

  // last handed-out slot stays inside the range
  a_last_range: assert property (@(posedge clk) disable iff (rst)
    32'(last_given) < 32'(NUM_IDS))
    else $error("last_given out of range");

  // a result is never overwritten while it still waits
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !out_load)
    else $error("result overwritten");

endmodule

FILE: tb/sv/tb_id_allocator_next_fit_core.sv
// Self-checking bench for id_allocator_next_fit_core: a next-fit bitmap model
// predicts each result beat. Depends on idal_pkg and the allocator RTL only.
module tb_id_allocator_next_fit_core;
  timeunit 1ns;
  timeprecision 1ps;

  import idal_pkg::*;

  localparam int ID_BASE  = DEF_FIRST_ID;
  localparam int ID_COUNT = DEF_NUM_IDS;
  localparam int ID_MAX   = (1 << ID_W) - 1;

  // the one command value the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one stream item toward the block
  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] id;
  } alloc_cmd_t;

  // one result beat, unpacked from m_tdata
  typedef struct packed {
    logic [ID_W-1:0] id_out;
    logic [1:0]      status;
    logic            in_use;
  } alloc_result_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [12:0] id_in, [15:13] zero
  logic [1:0]  s_tuser  = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [12:0] id_out, [14:13] status, [15] in_use

  id_allocator_next_fit_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Bitmap model: own copy of the used map and of the last slot handed out.
  // Reset state: all free, last slot at the top so the first grant is base.
  // ---------------------------------------------------------------------
  bit          id_used [ID_COUNT];
  int unsigned last_slot = ID_COUNT - 1;

  function automatic alloc_result_t next_fit_step(logic [1:0] cmd, logic [ID_W-1:0] id);
    alloc_result_t r;
    int unsigned   pos;
    int            slot;
    bit            found;
    bit            in_rng;
    r.id_out = id;
    r.status = ST_OK;
    r.in_use = 1'b0;
    slot     = int'(id) - ID_BASE;
    in_rng   = (slot >= 0) && (slot < ID_COUNT);
    case (cmd)
      CMD_ALLOC: begin
        // next fit: walk up from the slot after the last grant, wrap at top
        pos   = last_slot;
        found = 1'b0;
        for (int n = 0; n < ID_COUNT && !found; n++) begin
          pos = (pos + 1 >= ID_COUNT) ? 0 : pos + 1;
          if (!id_used[pos]) found = 1'b1;
        end
        if (found) begin
          id_used[pos] = 1'b1;
          last_slot    = pos;
          r.id_out     = ID_W'(ID_BASE + pos);
        end else begin
          // map full: nothing changes
          r.id_out = '0;
          r.status = ST_EXHAUSTED;
        end
      end
      CMD_RELEASE: begin
        // freeing an already free id is harmless
        if (in_rng) id_used[slot] = 1'b0;
        else        r.status      = ST_RANGE;
      end
      CMD_QUERY: begin
        if (in_rng) r.in_use = id_used[slot];
        else        r.status = ST_RANGE;
      end
      default: ;  // unused command: echo only
    endcase
    return r;
  endfunction

  alloc_cmd_t    pending_cmds[$];
  alloc_result_t expected_results[$];
  int            err_cnt  = 0;
  int            beat_cnt = 0;
  int            gen_allocs = 0;
  int            n_items  = 0;

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  task automatic add_item(logic [1:0] cmd, int id);
    alloc_cmd_t c;
    c.cmd = cmd;
    c.id  = id[ID_W-1:0];
    pending_cmds.push_back(c);
    if (cmd == CMD_ALLOC) gen_allocs++;
  endtask

  // in-range id close to where grants are currently landing
  function automatic int near_id();
    int off;
    off = (gen_allocs % ID_COUNT) + ID_COUNT + $urandom_range(0, 128) - 96;
    return ID_BASE + (off % ID_COUNT);
  endfunction

  function automatic int live_id();
    if ($urandom_range(0, 1) == 0) return near_id();
    return ID_BASE + $urandom_range(0, ID_COUNT - 1);
  endfunction

  // below, above, or anywhere in the 13-bit field
  function automatic int stray_id();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, ID_BASE - 1);
      1:       return $urandom_range(ID_BASE + ID_COUNT, ID_MAX);
      default: return $urandom_range(0, ID_MAX);
    endcase
  endfunction

  task automatic add_random(int count, int alloc_pct, int release_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
        add_item(CMD_ALLOC, $urandom_range(0, ID_MAX));  // id ignored, still random
      else if (r < alloc_pct + release_pct)
        add_item(CMD_RELEASE, live_id());
      else if (r < 88)
        add_item(CMD_QUERY, live_id());
      else if (r < 95)
        add_item($urandom_range(0, 1) ? CMD_RELEASE : CMD_QUERY, stray_id());
      else
        add_item(CMD_UNUSED, $urandom_range(0, ID_MAX));
    end
  endtask

  initial begin
    // directed: first grants, next-fit skip over a freed id, range edges
    add_item(CMD_QUERY,   ID_BASE);
    add_item(CMD_ALLOC,   0);
    add_item(CMD_QUERY,   ID_BASE);
    add_item(CMD_ALLOC,   ID_MAX);
    add_item(CMD_RELEASE, ID_BASE);
    add_item(CMD_QUERY,   ID_BASE);
    add_item(CMD_ALLOC,   0);            // must not reuse base yet
    add_item(CMD_RELEASE, ID_BASE + 2);
    add_item(CMD_RELEASE, ID_BASE + 2);  // release of a free id
    add_item(CMD_QUERY,   ID_BASE + 2);
    add_item(CMD_QUERY,   ID_BASE - 1);
    add_item(CMD_RELEASE, ID_BASE - 1);
    add_item(CMD_QUERY,   ID_BASE + ID_COUNT - 1);
    add_item(CMD_RELEASE, ID_BASE + ID_COUNT - 1);
    add_item(CMD_QUERY,   ID_BASE + ID_COUNT);
    add_item(CMD_RELEASE, ID_BASE + ID_COUNT);
    add_item(CMD_QUERY,   0);
    add_item(CMD_RELEASE, ID_MAX);
    add_item(CMD_QUERY,   ID_MAX);
    add_item(CMD_UNUSED,  ID_MAX);
    add_item(CMD_UNUSED,  0);
    add_item(CMD_QUERY,   ID_BASE + 1);
    gen_allocs = 3;

    add_random(450, 50, 20);

    // allocation burst: grants across several bitmap rows
    for (int i = 0; i < 300; i++) add_item(CMD_ALLOC, $urandom_range(0, ID_MAX));
    add_item(CMD_QUERY, ID_BASE + ID_COUNT - 1);

    // holes punched behind the pointer, then more grants and releases
    add_random(520, 35, 35);

    // every item gives exactly one result beat
    n_items = pending_cmds.size();
    wait (beat_cnt == n_items);
    // room for a stray extra beat to show up
    repeat (ID_COUNT / WORD_W + 40) @(posedge clk);
    err_cnt += expected_results.size();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: holds a beat until taken, predicts on acceptance
  // ---------------------------------------------------------------------
  alloc_cmd_t drv_cmd;
  int         drv_gap  = 0;
  bit         drv_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(next_fit_step(drv_cmd.cmd, drv_cmd.id));
        if ($urandom_range(0, 99) == 0) drv_calm = ($urandom_range(0, 2) == 0);
        drv_gap = pick_gap(drv_calm);
      end
      if (s_tvalid && !s_tready) begin
        // beat still offered: keep everything as is
      end else if (drv_gap > 0) begin
        drv_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        drv_cmd = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, drv_cmd.id};
        s_tuser  <= drv_cmd.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver ready: random stalls plus one long hold-off so the block
  // backs up and drops s_tready while the driver keeps offering
  // ---------------------------------------------------------------------
  int sink_cyc  = 0;
  int sink_gap  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit sink_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      sink_cyc++;
      if (sink_cyc % 200 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && sink_cyc >= 1500) begin
        hold_done = 1'b1;
        hold_left = 500;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_gap = pick_gap(sink_calm);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: each accepted result against the oldest prediction
  // ---------------------------------------------------------------------
  alloc_result_t mon_got;
  alloc_result_t mon_exp;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got.id_out = m_tdata[12:0];
      mon_got.status = m_tdata[14:13];
      mon_got.in_use = m_tdata[15];
      if (expected_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("result beat %0d with nothing expected: id %0d status %0d in_use %0d",
                   beat_cnt, mon_got.id_out, mon_got.status, mon_got.in_use);
      end else begin
        mon_exp = expected_results.pop_front();
        if (mon_got.id_out !== mon_exp.id_out || mon_got.status !== mon_exp.status ||
            mon_got.in_use !== mon_exp.in_use) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("beat %0d mismatch: exp id %0d st %0d use %0d, got id %0d st %0d use %0d",
                     beat_cnt, mon_exp.id_out, mon_exp.status, mon_exp.in_use,
                     mon_got.id_out, mon_got.status, mon_got.in_use);
        end
      end
      beat_cnt++;
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
